@@ design/hex_text_to_crc16_frame_core_macros.svh @@
// Assertion macros for the frame builder RTL.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef HEX_TEXT_TO_CRC16_FRAME_CORE_MACROS_SVH
`define HEX_TEXT_TO_CRC16_FRAME_CORE_MACROS_SVH

`ifndef SYNTH
`define HEXCRC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("hexcrc assertion failed");
`define HEXCRC_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hexcrc implication failed");
`define HEXCRC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hexcrc next-cycle implication failed");
`else
`define HEXCRC_ASSERT(lbl, prop)
`define HEXCRC_ASSERT_SAME(lbl, ante, cons)
`define HEXCRC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ design/hexcrc_pkg.sv @@
`default_nettype none

package hexcrc_pkg;

	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'hA001;
	localparam logic [7:0]  CHAR_SPACE = 8'd32;

	typedef struct packed {
		logic [15:0] crc;
		logic [3:0]  held;
		logic        have;
		logic        stopped;
	} parse_state_t;

	localparam parse_state_t STATE_INIT = '{crc: CRC_INIT, held: 4'h0, have: 1'b0,
		stopped: 1'b0};

	typedef struct packed {
		logic        pay_vld;
		logic [7:0]  pay_byte;
		logic        crc_vld;
		logic [15:0] crc;
	} parse_result_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} frame_entry_t;

	// Bit 4 set means the character is not a hex digit.
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] v;
		v = 5'h10;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = {1'b0, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = {1'b0, 4'(c - 8'h41 + 8'd10)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = {1'b0, 4'(c - 8'h61 + 8'd10)};
		end
		return v;
	endfunction

	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] r;
		r = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (r[0]) begin
				r = (r >> 1) ^ CRC_POLY;
			end else begin
				r = r >> 1;
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ design/hexcrc_char_if.sv @@
`default_nettype none

interface hexcrc_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       last_char;

	modport source (output valid, output char_in, output last_char, input ready);
	modport sink (input valid, input char_in, input last_char, output ready);
endinterface

`default_nettype wire

@@ design/hexcrc_byte_if.sv @@
`default_nettype none

interface hexcrc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

@@ design/hex_text_to_crc16_frame_core.sv @@
// Turns ASCII hex text, one character per word, into a byte frame closed by its
// CRC-16/MODBUS. Each character is decoded and folded into the CRC in the cycle it
// is accepted, so a character is taken every cycle while each produces at most one
// byte and out_ch.ready is high. The output side sends one byte per cycle, while
// out_ch.ready is high, from a three-entry frame buffer; a character that completes
// a byte and carries the last flag yields three bytes, and a last character without
// a byte yields two, so input then waits until one byte is left and being taken.
// The CRC low byte comes before the high byte, and out_last marks the high byte.
`default_nettype none

module hex_text_to_crc16_frame_core (
	input  var logic      clk,
	input  var logic      arst_n,
	hexcrc_char_if.sink   in_ch,
	hexcrc_byte_if.source out_ch
);
	import hexcrc_pkg::*;

	`include "hex_text_to_crc16_frame_core_macros.svh"

	parse_state_t  state_q;
	parse_state_t  state_nxt;
	parse_result_t res;
	frame_entry_t  ent_q [3];
	frame_entry_t  load [3];
	logic [1:0]    cnt_q;
	logic [1:0]    load_cnt;
	logic          in_acc;
	logic          out_acc;

	hexcrc_parse u_parse (
		.cur       (state_q),
		.char_in   (in_ch.char_in),
		.last_char (in_ch.last_char),
		.nxt       (state_nxt),
		.res       (res)
	);

	assign in_ch.ready     = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ch.ready);
	assign in_acc          = in_ch.valid && in_ch.ready;
	assign out_ch.valid    = (cnt_q != 2'd0);
	assign out_acc         = out_ch.valid && out_ch.ready;
	assign out_ch.out_byte = ent_q[0].data;
	assign out_ch.out_last = ent_q[0].last;

	always_comb begin
		load[0]  = '{data: res.crc[7:0], last: 1'b0};
		load[1]  = '{data: res.crc[15:8], last: 1'b1};
		load[2]  = '{data: res.crc[15:8], last: 1'b1};
		load_cnt = {res.crc_vld, 1'b0} + {1'b0, res.pay_vld};
		if (res.pay_vld) begin
			load[0] = '{data: res.pay_byte, last: 1'b0};
			load[1] = '{data: res.crc[7:0], last: 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_INIT;
			cnt_q   <= 2'd0;
		end else if (in_acc) begin
			state_q <= state_nxt;
			cnt_q   <= load_cnt;
		end else if (out_acc) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ent_q <= load;
		end else if (out_acc) begin
			ent_q[0] <= ent_q[1];
			ent_q[1] <= ent_q[2];
		end
	end

	`HEXCRC_ASSERT_SAME(a_last_is_final, out_ch.valid && out_ch.out_last, cnt_q == 2'd1)
	`HEXCRC_ASSERT_NEXT(a_last_gives_crc, in_acc && in_ch.last_char, cnt_q >= 2'd2)
	`HEXCRC_ASSERT_NEXT(a_last_resets, in_acc && in_ch.last_char, state_q == STATE_INIT)
	`HEXCRC_ASSERT(a_idle_ready, (cnt_q != 2'd0) || in_ch.ready)

endmodule

`default_nettype wire

@@ design/hexcrc_parse.sv @@
`default_nettype none

module hexcrc_parse (
	input  var hexcrc_pkg::parse_state_t  cur,
	input  var logic [7:0]                char_in,
	input  var logic                      last_char,
	output var hexcrc_pkg::parse_state_t  nxt,
	output var hexcrc_pkg::parse_result_t res
);
	import hexcrc_pkg::*;

	logic [4:0] v;
	logic [7:0] b;

	assign v = hex_value(char_in);
	assign b = {cur.held, v[3:0]};

	always_comb begin
		nxt = cur;
		res = '0;
		if (!cur.stopped) begin
			if (!cur.have) begin
				if (char_in == CHAR_SPACE) begin
					nxt = cur;
				end else if (v[4]) begin
					nxt.stopped = 1'b1;
				end else begin
					nxt.held = v[3:0];
					nxt.have = 1'b1;
				end
			end else begin
				nxt.have = 1'b0;
				nxt.held = 4'h0;
				if (v[4]) begin
					nxt.stopped = 1'b1;
				end else begin
					nxt.crc      = crc_update(cur.crc, b);
					res.pay_vld  = 1'b1;
					res.pay_byte = b;
				end
			end
		end
		if (last_char) begin
			res.crc_vld = 1'b1;
			res.crc     = nxt.crc;
			nxt         = STATE_INIT;
		end
	end

endmodule

`default_nettype wire

@@ tb/sv/crc_frame_checker.sv @@
`timescale 1ns / 100ps

module crc_frame_checker
	import hexcrc_pkg::*;
(
	input  var logic clk,
	input  var logic arst_n,
	hexcrc_char_if   text_ch,
	hexcrc_byte_if   frame_ch,
	output int       failures,
	output int       pending
);

	localparam logic [4:0] NOT_HEX = 5'h10;

	logic [15:0]  crc_run;
	logic [3:0]   held;
	logic         have;
	logic         stopped;
	frame_entry_t expected_frame[$];

	function automatic logic [4:0] digit_of(input logic [7:0] c);
		if (c >= "0" && c <= "9") begin
			return {1'b0, c[3:0]};
		end
		if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
			return {1'b0, c[3:0] + 4'd9};
		end
		return NOT_HEX;
	endfunction

	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] r;
		r = crc ^ {8'h00, b};
		repeat (8) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	task automatic clear_frame();
		crc_run = CRC_INIT;
		held = 4'h0;
		have = 1'b0;
		stopped = 1'b0;
	endtask

	task automatic take_char(input logic [7:0] c, input logic fin);
		logic [4:0] v;
		logic [7:0] b;
		v = digit_of(c);
		if (!stopped) begin
			if (!have) begin
				if (c != CHAR_SPACE) begin
					if (v == NOT_HEX) begin
						stopped = 1'b1;
					end else begin
						held = v[3:0];
						have = 1'b1;
					end
				end
			end else if (v == NOT_HEX) begin
				stopped = 1'b1;
				have = 1'b0;
				held = 4'h0;
			end else begin
				b = {held, v[3:0]};
				crc_run = crc16_step(crc_run, b);
				expected_frame.push_back('{data: b, last: 1'b0});
				have = 1'b0;
				held = 4'h0;
			end
		end
		if (fin) begin
			expected_frame.push_back('{data: crc_run[7:0], last: 1'b0});
			expected_frame.push_back('{data: crc_run[15:8], last: 1'b1});
			clear_frame();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		frame_entry_t want;
		if (!arst_n) begin
			clear_frame();
			expected_frame.delete();
			pending = 0;
		end else begin
			if (text_ch.valid && text_ch.ready) begin
				take_char(text_ch.char_in, text_ch.last_char);
			end
			if (frame_ch.valid && frame_ch.ready) begin
				if (expected_frame.size() == 0) begin
					failures++;
					$display("%0t: unexpected word, expected none, actual byte %h last %b",
						$time, frame_ch.out_byte, frame_ch.out_last);
				end else begin
					want = expected_frame.pop_front();
					if (frame_ch.out_byte !== want.data) begin
						failures++;
						$display("%0t: out_byte mismatch, expected %h, actual %h",
							$time, want.data, frame_ch.out_byte);
					end
					if (frame_ch.out_last !== want.last) begin
						failures++;
						$display("%0t: out_last mismatch, expected %b, actual %b",
							$time, want.last, frame_ch.out_last);
					end
				end
			end
			pending = expected_frame.size();
		end
	end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
	import hexcrc_pkg::*;

	localparam int TEXT_ITEMS = 350;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   failures;
	int   pending;
	int   sent = 0;
	logic steady = 1'b0;

	hexcrc_char_if text_ch();
	hexcrc_byte_if frame_ch();

	hex_text_to_crc16_frame_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (text_ch),
		.out_ch (frame_ch)
	);

	crc_frame_checker frame_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.text_ch  (text_ch),
		.frame_ch (frame_ch),
		.failures (failures),
		.pending  (pending)
	);

	always #2 clk = ~clk;

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10) begin
			return 8'("0") + 8'(v);
		end
		return ($urandom_range(0, 1) ? 8'("A") : 8'("a")) + 8'(v) - 8'd10;
	endfunction

	task automatic send_char(input logic [7:0] c, input logic fin);
		int g;
		g = steady ? 0 : gap_len();
		if (g != 0) begin
			text_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		text_ch.valid <= 1'b1;
		text_ch.char_in <= c;
		text_ch.last_char <= fin;
		do @(posedge clk); while (!text_ch.ready);
		sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_char(s[i], i == s.len() - 1);
		end
	endtask

	task automatic send_frame();
		logic [7:0] text[$];
		logic [7:0] val;
		int         nbytes;
		int         kind;
		nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(0, 6);
		for (int i = 0; i < nbytes; i++) begin
			if ($urandom_range(0, 4) == 0) begin
				text.push_back(CHAR_SPACE);
			end
			val = 8'($urandom_range(0, 255));
			text.push_back(hex_char(val[7:4]));
			text.push_back(hex_char(val[3:0]));
		end
		kind = $urandom_range(0, 9);
		case (kind)
			0: begin
				text.push_back(CHAR_SPACE);
			end
			1: begin
				text.push_back(hex_char(4'($urandom_range(0, 15))));
			end
			2: begin
				text.push_back(8'($urandom_range(0, 255)));
			end
			3: begin
				text.push_back("G");
			end
			default: begin
			end
		endcase
		if ($urandom_range(0, 6) == 0) begin
			text.insert($urandom_range(0, text.size()), 8'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 9) == 0) begin
			text.delete();
			repeat ($urandom_range(1, 8)) text.push_back(8'($urandom_range(0, 255)));
		end
		if (text.size() == 0) begin
			text.push_back(8'($urandom_range(0, 255)));
		end
		steady = ($urandom_range(0, 5) == 0);
		for (int i = 0; i < text.size(); i++) begin
			send_char(text[i], i == text.size() - 1);
		end
	endtask

	initial begin : drain
		int hold;
		frame_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			frame_ch.ready <= 1'b1;
			hold = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 12);
			repeat (hold) @(posedge clk);
			hold = gap_len();
			if (hold != 0) begin
				frame_ch.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		logic [7:0] edge_chars[8];
		logic       paused;
		edge_chars = '{8'h00, 8'hFF, "/", ":", "@", "G", 8'h60, "g"};
		paused = 1'b0;
		text_ch.valid <= 1'b0;
		text_ch.char_in <= 8'h00;
		text_ch.last_char <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_text("0aF9");
		send_text(" fA 7");
		send_text("1 2");
		send_text("G5");
		foreach (edge_chars[i]) begin
			send_char(edge_chars[i], 1'b1);
		end

		while (sent < TEXT_ITEMS) begin
			if (!paused && sent > TEXT_ITEMS / 2) begin
				paused = 1'b1;
				text_ch.valid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			send_frame();
		end
		text_ch.valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (failures == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("testbench: done, errors");
		$finish;
	end

endmodule
